### rtl/core/test_pattern_envelope_meter_macros.svh
// Assertion macros shared by the envelope meter RTL.
`ifndef TEST_PATTERN_ENVELOPE_METER_MACROS_SVH
`define TEST_PATTERN_ENVELOPE_METER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define TPEM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("envelope meter assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define TPEM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("envelope meter assertion failed");

`endif

### rtl/core/tpem_pkg.sv
// Types and constants of the test pattern envelope meter.
package tpem_pkg;

	localparam int NCH      = 8;
	localparam int OUT_BITS = 15;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_SCENARIO   = 3'd0,
		REG_TICK_MS    = 3'd1,
		REG_ATTACK     = 3'd2,
		REG_RELEASE    = 3'd3,
		REG_PEAK_THR   = 3'd4,
		REG_ACTIVE_THR = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SCN_SWEEP = 2'd0,
		SCN_DUAL  = 2'd1,
		SCN_PULSE = 2'd2,
		SCN_NONE  = 2'd3
	} scenario_t;

	// Filter coefficients handed to each channel lane.
	typedef struct packed {
		logic [15:0] attack;
		logic [15:0] rel;
	} coeff_t;

	// Register reset values.
	localparam logic [1:0]  SCENARIO_RST   = 2'd0;
	localparam logic [8:0]  TICK_MS_RST    = 9'd20;
	localparam logic [15:0] ATTACK_RST     = 16'd26214;
	localparam logic [15:0] RELEASE_RST    = 16'd5243;
	localparam logic [14:0] PEAK_THR_RST   = 15'd16384;
	localparam logic [14:0] ACTIVE_THR_RST = 15'd1638;

	// Time base.
	localparam logic [10:0] MS_PER_SEC   = 11'd1000;
	localparam logic [9:0]  PULSE_PERIOD = 10'd500;
	localparam logic [9:0]  PULSE_TWICE  = 10'd1000;
	localparam logic [8:0]  PULSE_ON_MS  = 9'd150;

	// Target levels in hundredths of full scale, rounded to nearest.
	localparam int PCT_SWEEP = 85;
	localparam int PCT_DUAL  = 80;
	localparam int PCT_PULSE = 90;
	localparam int PCT_ROUND = 50;
	localparam int PCT_SCALE = 100;

	localparam logic [2:0] CH_DUAL_A = 3'd0;
	localparam logic [2:0] CH_DUAL_B = 3'd5;
	localparam logic [2:0] CH_PULSE  = 3'd6;

endpackage

### rtl/core/tpem_lane.sv
// One channel of the envelope follower: attack/release one-pole step with clamping.
module tpem_lane #(
	parameter int LEVEL_BITS = 15
) (
	input  logic [LEVEL_BITS-1:0] level,
	input  logic [LEVEL_BITS-1:0] target,
	input  tpem_pkg::coeff_t      coeff,
	output logic [LEVEL_BITS-1:0] level_next
);
	import tpem_pkg::*;

	localparam int DW = LEVEL_BITS + 1;
	localparam int PW = LEVEL_BITS + 18;
	localparam int NW = LEVEL_BITS + 3;
	localparam logic signed [NW-1:0] LEVEL_MAX = NW'((1 << LEVEL_BITS) - 1);

	logic [15:0]           c_sel;
	logic signed [DW-1:0]  diff;
	logic signed [PW-1:0]  prod;
	logic signed [NW-1:0]  sum;

	always_comb begin
		c_sel = (target > level) ? coeff.attack : coeff.rel;
		diff  = $signed({1'b0, target}) - $signed({1'b0, level});
		prod  = PW'($signed({1'b0, c_sel})) * PW'(diff);
		// The arithmetic shift by 16 floors, also for a falling level.
		sum   = $signed({3'b000, level}) + NW'($signed(prod[PW-1:16]));
		if (sum < 0) begin
			level_next = '0;
		end else if (sum > LEVEL_MAX) begin
			level_next = LEVEL_MAX[LEVEL_BITS-1:0];
		end else begin
			level_next = sum[LEVEL_BITS-1:0];
		end
	end

endmodule

### rtl/core/test_pattern_envelope_meter.sv
// Top level of the test pattern envelope meter: time base, targets and eight followers.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | silent
//  out     | out_valid / out_ready| level_ch0..level_ch7, peak_mask, active
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// Unless the result stalls, one tick word is taken per cycle and passes both stages.
// Stage one advances the time counters and registers the eight targets; stage two runs
// the eight filter lanes in parallel into the level register, which is also the result.
// A stalled result holds the pipeline; the stage-one register keeps input ready high
// for one more word. Reset clears the levels and counters, with no clearing pass.
module test_pattern_envelope_meter #(
	parameter int LEVEL_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        silent,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] level_ch0,
	output logic [14:0] level_ch1,
	output logic [14:0] level_ch2,
	output logic [14:0] level_ch3,
	output logic [14:0] level_ch4,
	output logic [14:0] level_ch5,
	output logic [14:0] level_ch6,
	output logic [14:0] level_ch7,
	output logic [7:0]  peak_mask,
	output logic        active,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tpem_pkg::*;
	`include "test_pattern_envelope_meter_macros.svh"

	localparam int CMP_W = (LEVEL_BITS > OUT_BITS) ? LEVEL_BITS : OUT_BITS;
	localparam longint unsigned TGT_SWEEP_L =
		((longint'(PCT_SWEEP) << LEVEL_BITS) + PCT_ROUND) / PCT_SCALE;
	localparam longint unsigned TGT_DUAL_L =
		((longint'(PCT_DUAL) << LEVEL_BITS) + PCT_ROUND) / PCT_SCALE;
	localparam longint unsigned TGT_PULSE_L =
		((longint'(PCT_PULSE) << LEVEL_BITS) + PCT_ROUND) / PCT_SCALE;
	localparam logic [LEVEL_BITS-1:0] TGT_SWEEP = LEVEL_BITS'(TGT_SWEEP_L);
	localparam logic [LEVEL_BITS-1:0] TGT_DUAL  = LEVEL_BITS'(TGT_DUAL_L);
	localparam logic [LEVEL_BITS-1:0] TGT_PULSE = LEVEL_BITS'(TGT_PULSE_L);

	// Configuration registers.
	scenario_t   scenario_q;
	logic [8:0]  tick_q;
	coeff_t      coeff_q;
	logic [14:0] peak_thr_q;
	logic [14:0] active_thr_q;

	// Time base.
	logic [9:0]  ms_q;
	logic [2:0]  sweep_q;
	logic [8:0]  phase_q;
	logic [10:0] ms_sum;
	logic        sec_wrap;
	logic [9:0]  ms_d;
	logic [2:0]  sweep_d;
	logic [9:0]  phase_sum;
	logic [8:0]  phase_d;

	// Pipeline.
	logic                  in_take;
	logic                  s1_adv;
	logic                  s1_valid_q;
	logic                  silent_s1;
	logic [LEVEL_BITS-1:0] target_d [NCH];
	logic [LEVEL_BITS-1:0] target_s1 [NCH];
	logic [LEVEL_BITS-1:0] level_q [NCH];
	logic [LEVEL_BITS-1:0] level_d [NCH];
	logic                  out_valid_q;
	logic                  levels_zero;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scenario_q   <= scenario_t'(SCENARIO_RST);
			tick_q       <= TICK_MS_RST;
			coeff_q      <= '{attack: ATTACK_RST, rel: RELEASE_RST};
			peak_thr_q   <= PEAK_THR_RST;
			active_thr_q <= ACTIVE_THR_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCENARIO:   scenario_q   <= scenario_t'(cfg_data[1:0]);
				REG_TICK_MS:    tick_q       <= cfg_data[8:0];
				REG_ATTACK:     coeff_q.attack <= cfg_data;
				REG_RELEASE:    coeff_q.rel  <= cfg_data;
				REG_PEAK_THR:   peak_thr_q   <= cfg_data[14:0];
				REG_ACTIVE_THR: active_thr_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Time counters advance on the accepted tick, and its targets use the new values.
	always_comb begin
		ms_sum    = {1'b0, ms_q} + {2'b00, tick_q};
		sec_wrap  = (ms_sum >= MS_PER_SEC);
		ms_d      = sec_wrap ? 10'(ms_sum - MS_PER_SEC) : ms_sum[9:0];
		sweep_d   = sweep_q + {2'b00, sec_wrap};
		phase_sum = {1'b0, phase_q} + {1'b0, tick_q};
		if (phase_sum >= PULSE_TWICE) begin
			phase_d = 9'(phase_sum - PULSE_TWICE);
		end else if (phase_sum >= PULSE_PERIOD) begin
			phase_d = 9'(phase_sum - PULSE_PERIOD);
		end else begin
			phase_d = phase_sum[8:0];
		end
	end

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			target_d[c] = '0;
			if (!silent) begin
				case (scenario_q)
					SCN_SWEEP: if (sweep_d == 3'(c)) target_d[c] = TGT_SWEEP;
					SCN_DUAL:  if (3'(c) == CH_DUAL_A || 3'(c) == CH_DUAL_B)
						target_d[c] = TGT_DUAL;
					SCN_PULSE: if (3'(c) == CH_PULSE && phase_d < PULSE_ON_MS)
						target_d[c] = TGT_PULSE;
					default: target_d[c] = '0;
				endcase
			end
		end
	end

	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q        <= '0;
			sweep_q     <= '0;
			phase_q     <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NCH; c++) level_q[c] <= '0;
		end else begin
			if (in_take) begin
				ms_q    <= ms_d;
				sweep_q <= sweep_d;
				phase_q <= phase_d;
			end
			if (in_take) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				for (int c = 0; c < NCH; c++) level_q[c] <= level_d[c];
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			silent_s1 <= silent;
			for (int c = 0; c < NCH; c++) target_s1[c] <= target_d[c];
		end
	end

	for (genvar g = 0; g < NCH; g++) begin : g_lane
		tpem_lane #(
			.LEVEL_BITS(LEVEL_BITS)
		) u_lane (
			.level     (level_q[g]),
			.target    (target_s1[g]),
			.coeff     (coeff_q),
			.level_next(level_d[g])
		);
	end

	// Level register is the result; users change thresholds only while idle (unenforced).
	always_comb begin
		peak_mask   = '0;
		active      = 1'b0;
		levels_zero = 1'b1;
		for (int c = 0; c < NCH; c++) begin
			if (CMP_W'(level_q[c]) >= CMP_W'(peak_thr_q)) peak_mask[c] = 1'b1;
			if (CMP_W'(level_q[c]) >= CMP_W'(active_thr_q)) active = 1'b1;
			if (level_q[c] != '0) levels_zero = 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign level_ch0 = OUT_BITS'(level_q[0]);
	assign level_ch1 = OUT_BITS'(level_q[1]);
	assign level_ch2 = OUT_BITS'(level_q[2]);
	assign level_ch3 = OUT_BITS'(level_q[3]);
	assign level_ch4 = OUT_BITS'(level_q[4]);
	assign level_ch5 = OUT_BITS'(level_q[5]);
	assign level_ch6 = OUT_BITS'(level_q[6]);
	assign level_ch7 = OUT_BITS'(level_q[7]);

	`TPEM_ASSERT_NOW(a_counters_range, 1'b1, ms_q < 10'd1000 && phase_q < 9'd500)
	`TPEM_ASSERT_NOW(a_full_stage_blocks, s1_valid_q && !s1_adv, !in_ready)
	`TPEM_ASSERT_NEXT(a_result_follows, s1_adv, out_valid_q)
	`TPEM_ASSERT_NEXT(a_silent_holds_zero, s1_adv && silent_s1 && levels_zero, levels_zero)

endmodule

### tb/tb_test_pattern_envelope_meter.sv
// Testbench of the test pattern envelope meter: directed and random ticks checked against a predictor.
`timescale 1ns / 100ps

module tb_test_pattern_envelope_meter;
	import tpem_pkg::*;

	typedef struct packed {
		logic [7:0][14:0] level;
		logic [7:0]       peak;
		logic             act;
	} meter_word_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic        silent     = 1'b0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [14:0] level_ch0, level_ch1, level_ch2, level_ch3;
	logic [14:0] level_ch4, level_ch5, level_ch6, level_ch7;
	logic [7:0]  peak_mask;
	logic        active;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index  = 3'd0;
	logic [15:0] cfg_data   = 16'd0;

	// Pending tick words, expected result words and handshake shaping.
	logic        tick_q[$];
	meter_word_t expected_words[$];
	int          tx_gap      = 0;
	int          rx_gap      = 0;
	bit          tx_steady   = 1'b0;
	bit          rx_steady   = 1'b0;
	bit          pressure_go = 1'b0;
	logic        hold_off    = 1'b0;
	int          mismatches  = 0;

	// Predictor state and its copy of the registers.
	logic [7:0][14:0] m_level;
	int               m_ms;
	logic [2:0]       m_sweep;
	int               m_phase;
	scenario_t        m_scenario;
	logic [8:0]       m_tick;
	logic [15:0]      m_attack;
	logic [15:0]      m_release;
	logic [14:0]      m_peak_thr;
	logic [14:0]      m_active_thr;

	test_pattern_envelope_meter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.silent    (silent),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.level_ch0 (level_ch0),
		.level_ch1 (level_ch1),
		.level_ch2 (level_ch2),
		.level_ch3 (level_ch3),
		.level_ch4 (level_ch4),
		.level_ch5 (level_ch5),
		.level_ch6 (level_ch6),
		.level_ch7 (level_ch7),
		.peak_mask (peak_mask),
		.active    (active),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [14:0] pct_level(input int pct);
		return 15'(((pct << 15) + PCT_ROUND) / PCT_SCALE);
	endfunction

	// One-pole step; the arithmetic shift floors, as the block does.
	function automatic logic [14:0] follow_level(input logic [14:0] lvl, input logic [14:0] tgt);
		logic [15:0]        k;
		logic signed [16:0] diff;
		logic signed [33:0] prod;
		logic signed [33:0] next;
		k    = (tgt > lvl) ? m_attack : m_release;
		diff = $signed({2'b00, tgt}) - $signed({2'b00, lvl});
		prod = $signed({1'b0, k}) * diff;
		next = $signed({19'd0, lvl}) + (prod >>> 16);
		if (next < 0)
			return 15'd0;
		if (next > 32767)
			return 15'h7fff;
		return next[14:0];
	endfunction

	function automatic meter_word_t advance_meter(input logic quiet);
		logic [7:0][14:0] goal;
		meter_word_t      w;
		m_ms = m_ms + int'(m_tick);
		if (m_ms >= int'(MS_PER_SEC)) begin
			m_ms    = m_ms - int'(MS_PER_SEC);
			m_sweep = m_sweep + 3'd1;
		end
		m_phase = (m_phase + int'(m_tick)) % int'(PULSE_PERIOD);
		goal = '0;
		if (!quiet) begin
			case (m_scenario)
				SCN_SWEEP: goal[m_sweep] = pct_level(PCT_SWEEP);
				SCN_DUAL: begin
					goal[CH_DUAL_A] = pct_level(PCT_DUAL);
					goal[CH_DUAL_B] = pct_level(PCT_DUAL);
				end
				SCN_PULSE: begin
					if (m_phase < int'(PULSE_ON_MS))
						goal[CH_PULSE] = pct_level(PCT_PULSE);
				end
				default: ;
			endcase
		end
		w = '0;
		for (int c = 0; c < NCH; c++) begin
			m_level[c] = follow_level(m_level[c], goal[c]);
			w.level[c] = m_level[c];
			if (m_level[c] >= m_peak_thr)
				w.peak[c] = 1'b1;
			if (m_level[c] >= m_active_thr)
				w.act = 1'b1;
		end
		return w;
	endfunction

	task automatic note_mismatch(input string field, input int unsigned want, input int unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0d, got %0d", field, want, got);
	endtask

	// Tick sender: holds a word until it is taken, then idles for a random gap unless steady.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			silent   <= 1'b0;
			tx_gap   <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_words.push_back(advance_meter(silent));
			if (!(in_valid && !in_ready)) begin
				if (tx_gap != 0) begin
					in_valid <= 1'b0;
					tx_gap   <= tx_gap - 1;
				end else if (tick_q.size() != 0) begin
					in_valid <= 1'b1;
					silent   <= tick_q.pop_front();
					tx_gap   <= tx_steady ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver and checker.
	always @(posedge clk or negedge arst_n) begin : rx_side
		meter_word_t want;
		meter_word_t got;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_gap    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result word with no tick pending, levels %h", {level_ch7,
							level_ch6, level_ch5, level_ch4, level_ch3, level_ch2, level_ch1,
							level_ch0});
				end else begin
					want      = expected_words.pop_front();
					got.level = {level_ch7, level_ch6, level_ch5, level_ch4,
						level_ch3, level_ch2, level_ch1, level_ch0};
					got.peak  = peak_mask;
					got.act   = active;
					for (int c = 0; c < NCH; c++) begin
						if (got.level[c] !== want.level[c])
							note_mismatch($sformatf("level_ch%0d", c), want.level[c], got.level[c]);
					end
					if (got.peak !== want.peak)
						note_mismatch("peak_mask", want.peak, got.peak);
					if (got.act !== want.act)
						note_mismatch("active", want.act, got.act);
				end
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (rx_gap != 0) begin
				out_ready <= 1'b0;
				rx_gap    <= rx_gap - 1;
			end else begin
				out_ready <= 1'b1;
				if (!rx_steady && $urandom_range(0, 3) == 0)
					rx_gap <= pick_gap();
			end
		end
	end

	// Long receiver stall while the sender keeps offering, so the block backs up.
	initial begin : receiver_holdoff
		int n;
		wait (pressure_go);
		@(posedge clk);
		hold_off <= 1'b1;
		for (n = 0; n < 200; n++)
			@(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#1000000;
		$display("test_pattern_envelope_meter verification failed");
		$finish;
	end

	task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SCENARIO:   m_scenario   = scenario_t'(val[1:0]);
			REG_TICK_MS:    m_tick       = val[8:0];
			REG_ATTACK:     m_attack     = val;
			REG_RELEASE:    m_release    = val;
			REG_PEAK_THR:   m_peak_thr   = val[14:0];
			REG_ACTIVE_THR: m_active_thr = val[14:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (tick_q.size() != 0 || in_valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_ticks(input int count, input int quiet_pct);
		repeat (count)
			tick_q.push_back($urandom_range(0, 99) < quiet_pct);
		drain();
	endtask

	initial begin : stimulus
		int r;
		m_level      = '0;
		m_ms         = 0;
		m_sweep      = 3'd0;
		m_phase      = 0;
		m_scenario   = scenario_t'(SCENARIO_RST);
		m_tick       = TICK_MS_RST;
		m_attack     = ATTACK_RST;
		m_release    = RELEASE_RST;
		m_peak_thr   = PEAK_THR_RST;
		m_active_thr = ACTIVE_THR_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// Fast sweep with full attack and a zero release, so old channels hold.
		cfg_write(REG_SCENARIO, {14'd0, SCN_SWEEP});
		cfg_write(REG_TICK_MS, 16'd500);
		cfg_write(REG_ATTACK, 16'hffff);
		cfg_write(REG_RELEASE, 16'd0);
		cfg_write(REG_PEAK_THR, 16'd0);
		cfg_write(REG_ACTIVE_THR, 16'h7fff);
		send_ticks(6, 0);
		send_ticks(2, 100);

		// No pattern and a frozen time base; full release drains the levels.
		cfg_write(REG_SCENARIO, {14'd0, SCN_NONE});
		cfg_write(REG_TICK_MS, 16'd0);
		cfg_write(REG_RELEASE, 16'hffff);
		cfg_write(REG_PEAK_THR, 16'h7fff);
		cfg_write(REG_ACTIVE_THR, 16'd0);
		send_ticks(3, 0);

		// Dual pattern with the largest tick; a zero attack holds the levels first.
		cfg_write(REG_SCENARIO, {14'd0, SCN_DUAL});
		cfg_write(REG_TICK_MS, 16'd511);
		cfg_write(REG_ATTACK, 16'd0);
		cfg_write(REG_RELEASE, {16'd5243});
		cfg_write(REG_PEAK_THR, {1'b0, PEAK_THR_RST});
		cfg_write(REG_ACTIVE_THR, {1'b0, ACTIVE_THR_RST});
		send_ticks(2, 0);
		cfg_write(REG_ATTACK, ATTACK_RST);
		send_ticks(3, 0);
		send_ticks(1, 100);

		cfg_write(REG_SCENARIO, {14'd0, SCN_PULSE});
		cfg_write(REG_TICK_MS, 16'd50);
		send_ticks(6, 0);

		for (int p = 0; p < 11; p++) begin
			tx_steady = (p % 4 == 3) || (p == 2);
			rx_steady = (p % 5 == 4);
			cfg_write(REG_SCENARIO, {14'd0, 2'($urandom_range(0, 3))});
			r = $urandom_range(0, 99);
			if (r < 10)
				cfg_write(REG_TICK_MS, 16'd0);
			else if (r < 20)
				cfg_write(REG_TICK_MS, 16'd511);
			else if (r < 30)
				cfg_write(REG_TICK_MS, 16'd500);
			else
				cfg_write(REG_TICK_MS, 16'($urandom_range(1, 500)));
			if (p == 10) begin
				cfg_write(REG_ATTACK, 16'hffff);
				cfg_write(REG_RELEASE, 16'hffff);
			end else begin
				cfg_write(REG_ATTACK, 16'($urandom_range(0, 65535)));
				cfg_write(REG_RELEASE, 16'($urandom_range(0, 65535)));
			end
			cfg_write(REG_PEAK_THR, 16'($urandom_range(0, 30000)));
			cfg_write(REG_ACTIVE_THR, 16'($urandom_range(0, 20000)));
			if (p == 2)
				pressure_go = 1'b1;
			send_ticks(68, 15);
		end

		drain();
		if (mismatches == 0 && expected_words.size() == 0)
			$display("test_pattern_envelope_meter verification clean");
		else
			$display("test_pattern_envelope_meter verification failed");
		$finish;
	end

endmodule
